[hdl/fih_pkg.sv]
// Shared types and constants for the flux interval histogram.
`timescale 1ns / 1ps

package fih_pkg;

   // Default histogram geometry.
   localparam int SLOTS_PER_US_DFLT = 8;
   localparam int RANGE_US_DFLT     = 10;

   // Rounding constants of the slot formula (d*slots_per_us + 500) / 1000.
   localparam int ROUND_HALF_NS = 500;
   localparam int NS_PER_US     = 1000;

   // Scaled slot numerator: below (4096 + 1) * 1000, so 22 bits always suffice.
   localparam int STAMP_X_WIDTH = 22;

   // Reciprocal of 1000: x / 1000 == (x * RECIP_MULT) >> RECIP_SHIFT for x < 2**22.
   localparam int                RECIP_SHIFT = 32;
   localparam logic [22:0]       RECIP_MULT  = 23'd4294968;

   // Register defaults and limits.
   localparam logic [6:0]  LEVELS_RESET = 7'd16;
   localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

   // Request kinds.
   localparam logic [1:0] KIND_STAMP = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // One request transaction.
   typedef struct packed {
      logic [1:0]  kind;
      logic [30:0] timestamp;
      logic [6:0]  bin_index;
   } req_type;

   // One response transaction.
   typedef struct packed {
      logic [31:0] bin_count;
      logic [7:0]  scaled_height;
      logic [31:0] peak_count;
      logic [30:0] longest_interval;
      logic [31:0] overflow_count;
      logic        empty_res;
   } rsp_type;

   // Classified job handed from the front end to the back end.
   typedef struct packed {
      logic [1:0]               kind;
      logic                     negative;
      logic                     in_range;
      logic [30:0]              interval;
      logic [STAMP_X_WIDTH-1:0] slot_num;
      logic [6:0]               bin_index;
   } job_type;

   // Queue status seen by the back end and by the top level (busy).
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

[hdl/fih_front.sv]
// Front end: accepts requests, forms the interval and classifies it.
`timescale 1ns / 1ps

module fih_front #(
   parameter int SLOTS_PER_US = fih_pkg::SLOTS_PER_US_DFLT,
   parameter int RANGE_US     = fih_pkg::RANGE_US_DFLT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  fih_pkg::req_type req,
   output logic             push,
   output fih_pkg::job_type push_job
);
   import fih_pkg::*;

   localparam int SLOTS = SLOTS_PER_US * RANGE_US;
   // Largest interval whose rounded slot still lands inside the histogram.
   localparam int INTERVAL_LIMIT = ((SLOTS + 1) * NS_PER_US - ROUND_HALF_NS - 1) / SLOTS_PER_US;
   localparam logic [30:0] LIMIT_NS = 31'(INTERVAL_LIMIT);

   logic [30:0] prev_time_ff;
   logic [30:0] prev_time_in;
   logic [31:0] diff;
   logic [31:0] scaled;

   // Interval from the previous timestamp; the top bit flags a negative one.
   assign diff   = {1'b0, req.timestamp} - {1'b0, prev_time_ff};
   assign scaled = 32'(diff[STAMP_X_WIDTH-1:0]) * 32'(SLOTS_PER_US) + 32'(ROUND_HALF_NS);

   // Classify the transaction and build the job.
   always_comb begin
      push_job.kind      = req.kind;
      push_job.negative  = diff[31];
      push_job.interval  = diff[30:0];
      push_job.in_range  = !diff[31] && (diff[30:0] <= LIMIT_NS);
      push_job.slot_num  = scaled[STAMP_X_WIDTH-1:0];
      push_job.bin_index = req.bin_index;
      push = accept && ((req.kind == KIND_STAMP) || (req.kind == KIND_READ) ||
                        (req.kind == KIND_CLEAR));
   end

   // The previous timestamp survives a clear.
   always_comb begin
      prev_time_in = prev_time_ff;
      if (accept && (req.kind == KIND_STAMP)) begin
         prev_time_in = req.timestamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff <= '0;
      end else begin
         prev_time_ff <= prev_time_in;
      end
   end

endmodule

[hdl/fih_queue.sv]
// Two-entry job queue between the front end and the back end.
`timescale 1ns / 1ps

module fih_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  fih_pkg::job_type      push_job,
   input  logic                  pop,
   output fih_pkg::job_type      head_job,
   output fih_pkg::q_status_type status
);
   import fih_pkg::*;

   job_type    slots_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign head_job     = slots_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

   // Pointer and occupancy bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[hdl/fih_back.sv]
// Back end: bin memory updates, totals and scaled read-back.
`timescale 1ns / 1ps

module fih_back #(
   parameter int SLOTS_PER_US = fih_pkg::SLOTS_PER_US_DFLT,
   parameter int RANGE_US     = fih_pkg::RANGE_US_DFLT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [6:0]            levels,
   input  fih_pkg::job_type      head_job,
   input  fih_pkg::q_status_type status,
   output logic                  pop,
   output logic                  rsp_strobe,
   output fih_pkg::rsp_type      rsp
);
   import fih_pkg::*;

   localparam int SLOTS      = SLOTS_PER_US * RANGE_US;
   localparam int DEPTH      = SLOTS + 1;
   localparam int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [31:0] SLOTS_U = 32'(SLOTS);
   localparam int PROD_WIDTH = STAMP_X_WIDTH + 23;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SLOT   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_WRITE  = 3'd3;
   localparam logic [2:0] ST_SCALE  = 3'd4;
   localparam logic [2:0] ST_DIVIDE = 3'd5;

   logic [2:0]            state_ff, state_in;
   job_type               job_ff, job_in;
   logic [ADDR_WIDTH-1:0] addr_ff, addr_in;
   logic                  oor_ff, oor_in;
   logic                  is_read_ff, is_read_in;
   logic [30:0]           longest_ff, longest_in;
   logic [31:0]           peak_ff, peak_in;
   logic [31:0]           ovf_ff, ovf_in;
   logic [DEPTH-1:0]      valid_ff, valid_in;
   logic [31:0]           cnt_ff, cnt_in;
   logic [40:0]           rem_ff, rem_in;
   logic [7:0]            quo_ff, quo_in;
   logic [2:0]            step_ff, step_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  strobe_ff, strobe_in;

   logic [31:0]           bins_mem [DEPTH];
   logic [31:0]           rd_data_ff;
   logic                  rd_valid_ff;
   logic                  mem_we;
   logic [31:0]           wr_data;

   logic [PROD_WIDTH-1:0] slot_prod;
   logic [31:0]           cur_cnt;
   logic [39:0]           scale_prod;
   logic [40:0]           trial;
   logic                  quo_bit;
   logic [7:0]            quo_next;

   // Slot number by reciprocal multiplication; height numerator product.
   assign slot_prod  = PROD_WIDTH'(job_ff.slot_num) * PROD_WIDTH'(RECIP_MULT);
   assign cur_cnt    = rd_valid_ff ? rd_data_ff : 32'd0;
   assign scale_prod = 40'({levels, 1'b0}) * 40'(oor_ff ? 32'd0 : cur_cnt);
   assign trial      = 41'(peak_ff) << step_ff;
   assign quo_bit    = (rem_ff >= trial);
   assign quo_next   = quo_ff | (8'(quo_bit) << step_ff);
   assign wr_data    = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 32'd1;

   assign pop        = (state_ff == ST_IDLE) && !status.empty;
   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

   // Sequencer for stamp, read and clear jobs.
   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      addr_in    = addr_ff;
      oor_in     = oor_ff;
      is_read_in = is_read_ff;
      longest_in = longest_ff;
      peak_in    = peak_ff;
      ovf_in     = ovf_ff;
      valid_in   = valid_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      step_in    = step_ff;
      rsp_in     = rsp_ff;
      strobe_in  = 1'b0;
      mem_we     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!status.empty) begin
               case (head_job.kind)
                  KIND_STAMP: begin
                     job_in     = head_job;
                     is_read_in = 1'b0;
                     state_in   = ST_SLOT;
                  end
                  KIND_READ: begin
                     addr_in    = ADDR_WIDTH'(head_job.bin_index);
                     oor_in     = (32'(head_job.bin_index) > SLOTS_U);
                     is_read_in = 1'b1;
                     state_in   = ST_READ;
                  end
                  KIND_CLEAR: begin
                     valid_in   = '0;
                     longest_in = '0;
                     peak_in    = '0;
                     ovf_in     = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SLOT: begin
            if (!job_ff.negative && (job_ff.interval > longest_ff)) begin
               longest_in = job_ff.interval;
            end
            if (job_ff.in_range) begin
               addr_in  = ADDR_WIDTH'(slot_prod >> RECIP_SHIFT);
               state_in = ST_READ;
            end else begin
               if (ovf_ff != COUNT_MAX) begin
                  ovf_in = ovf_ff + 32'd1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = is_read_ff ? ST_SCALE : ST_WRITE;
         end
         ST_WRITE: begin
            mem_we            = 1'b1;
            valid_in[addr_ff] = 1'b1;
            if (wr_data > peak_ff) begin
               peak_in = wr_data;
            end
            state_in = ST_IDLE;
         end
         ST_SCALE: begin
            cnt_in   = oor_ff ? 32'd0 : cur_cnt;
            rem_in   = 41'(scale_prod) + 41'(peak_ff >> 1);
            quo_in   = '0;
            step_in  = 3'd7;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            // One quotient bit per cycle, most significant first.
            if (quo_bit) begin
               rem_in = rem_ff - trial;
            end
            quo_in = quo_next;
            if (step_ff == 3'd0) begin
               rsp_in.bin_count        = cnt_ff;
               rsp_in.scaled_height    = (peak_ff == 32'd0) ? 8'd0 : quo_next;
               rsp_in.peak_count       = peak_ff;
               rsp_in.longest_interval = longest_ff;
               rsp_in.overflow_count   = ovf_ff;
               rsp_in.empty_res        = (peak_ff == 32'd0);
               strobe_in               = 1'b1;
               state_in                = ST_IDLE;
            end else begin
               step_in = step_ff - 3'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         longest_ff <= '0;
         peak_ff    <= '0;
         ovf_ff     <= '0;
         valid_ff   <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         longest_ff <= longest_in;
         peak_ff    <= peak_in;
         ovf_ff     <= ovf_in;
         valid_ff   <= valid_in;
         strobe_ff  <= strobe_in;
      end
   end

   // Working registers carry no reset.
   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      addr_ff     <= addr_in;
      oor_ff      <= oor_in;
      is_read_ff  <= is_read_in;
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      rsp_ff      <= rsp_in;
      rd_valid_ff <= valid_ff[addr_ff];
   end

   // Bin memory with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bins_mem[addr_ff] <= wr_data;
      end
      rd_data_ff <= bins_mem[addr_ff];
   end

endmodule

[hdl/flux_interval_histogram.sv]
// Top level of the flux transition interval histogram.
//
//   Channel   Ports                                     Direction
//   --------  ----------------------------------------  ---------
//   request   start, busy, req (kind/timestamp/index)   in
//   response  rsp_strobe, rsp (counts and totals)       out
//   config    csr_write_enable, csr_write_data         in
//
// Back end states: dispatch, slot multiply, bin read and bin write for an in-range timestamp,
// dispatch and slot multiply for an out-of-range one, dispatch alone for a clear, and for a read
// dispatch, bin read, numerator setup and 8 divider steps, whose response shows the cycle after.
// A two-entry queue holds requests; busy rises when it is full.
// Reset is synchronous and zeroes all bins (through per-bin valid flags) and totals.
// Each response is shown for one cycle only; the receiver cannot stall it.
`timescale 1ns / 1ps

module flux_interval_histogram #(
   parameter int SLOTS_PER_US = fih_pkg::SLOTS_PER_US_DFLT,
   parameter int RANGE_US     = fih_pkg::RANGE_US_DFLT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fih_pkg::req_type req,
   output logic             rsp_strobe,
   output fih_pkg::rsp_type rsp,
   input  logic             csr_write_enable,
   input  logic [6:0]       csr_write_data
);
   import fih_pkg::*;

   logic         accept;
   logic         push;
   logic         pop;
   job_type      push_job;
   job_type      head_job;
   q_status_type q_status;
   logic [6:0]   levels_ff;
   logic [6:0]   levels_in;

   assign busy   = q_status.full;
   assign accept = start && !busy;

   // Levels register.
   always_comb begin
      levels_in = levels_ff;
      if (csr_write_enable) begin
         levels_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= LEVELS_RESET;
      end else begin
         levels_ff <= levels_in;
      end
   end

   fih_front #(
      .SLOTS_PER_US(SLOTS_PER_US),
      .RANGE_US    (RANGE_US)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req),
      .push    (push),
      .push_job(push_job)
   );

   fih_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_job(push_job),
      .pop     (pop),
      .head_job(head_job),
      .status  (q_status)
   );

   fih_back #(
      .SLOTS_PER_US(SLOTS_PER_US),
      .RANGE_US    (RANGE_US)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .levels    (levels_ff),
      .head_job  (head_job),
      .status    (q_status),
      .pop       (pop),
      .rsp_strobe(rsp_strobe),
      .rsp       (rsp)
   );

   // A response transaction lasts exactly one cycle.
   a_single_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

   // The scaled height never exceeds twice the level setting.
   a_height_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp.scaled_height <= {levels_ff, 1'b0}))
      else $error("scaled height above twice the levels");

   // No bin can hold more than the tracked peak.
   a_count_peak : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp.bin_count <= rsp.peak_count))
      else $error("bin count above peak count");

   // An empty histogram reports zero counts.
   a_empty_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp.empty_res) |-> ((rsp.bin_count == 32'd0) &&
                                         (rsp.scaled_height == 8'd0)))
      else $error("empty histogram reported a nonzero bin");

endmodule
